// File: sv/bct_pkg.sv
// Package for the bone chain transform block.
// Shared constants, the sequencer state type and a saturation function; depends on nothing.
package bct_pkg;
   localparam int MaxBones = 256;
   localparam int BoneBits = $clog2(MaxBones);
   localparam int MemDepth = MaxBones * 4;
   localparam int MemAddrBits = $clog2(MemDepth);
   localparam int MemWidth = 96;

   localparam logic [2:0] RegBoneMask = 3'd0;
   localparam logic [2:0] RegYawCos = 3'd1;
   localparam logic [2:0] RegYawSin = 3'd2;
   localparam logic [2:0] RegOriginX = 3'd3;
   localparam logic [2:0] RegOriginY = 3'd4;
   localparam logic [2:0] RegOriginZ = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOCAL, ST_READ, ST_ROW, ST_OUT
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
      if (v > 70'sd2147483647) return 32'sh7fffffff;
      if (v < -70'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction
endpackage

// File: sv/bct_ram.sv
// Generic single port RAM with registered read.
// Depends on nothing.
module bct_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[addr] <= wr_data;
      rd_data <= mem_ff[addr];
   end
endmodule

// File: sv/bone_chain_transform.sv
// Top level of the bone chain transform: registers, sequencer, row datapath.
// Depends on bct_pkg and bct_ram.
//
// Bones are taken one at a time. The local rotation is formed in ST_LOCAL through
// three shared 18x18 multipliers. Each world row then passes through a parent
// memory read state (ST_READ), a multiply state (ST_ROW) and an output state
// (ST_OUT), and the output state stretches while rsp_ready is low. The rotation
// part of each world row lives in a 96-bit memory and its translation in a 32-bit
// memory, one word per row. A skipped bone is accepted in ST_IDLE and gives no
// items.
module bone_chain_transform (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_bone_index,
   input  logic signed [8:0]  req_parent_index,
   input  logic [31:0]        req_bone_flags,
   input  logic signed [17:0] req_quat_w,
   input  logic signed [17:0] req_quat_x,
   input  logic signed [17:0] req_quat_y,
   input  logic signed [17:0] req_quat_z,
   input  logic signed [31:0] req_local_x,
   input  logic signed [31:0] req_local_y,
   input  logic signed [31:0] req_local_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_bone,
   output logic [1:0]         rsp_row,
   output logic signed [31:0] rsp_col0,
   output logic signed [31:0] rsp_col1,
   output logic signed [31:0] rsp_col2,
   output logic signed [31:0] rsp_translation,
   output logic               rsp_last_row,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   logic [31:0] mask_ff;
   logic signed [17:0] cos_ff, sin_ff;
   logic signed [31:0] ox_ff, oy_ff, oz_ff;
   logic [2:0] ridx;
   assign ridx = csr_paddr[4:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0; cos_ff <= 18'sd65536; sin_ff <= '0;
         ox_ff <= '0; oy_ff <= '0; oz_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (ridx)
            bct_pkg::RegBoneMask: mask_ff <= csr_pwdata;
            bct_pkg::RegYawCos: cos_ff <= csr_pwdata[17:0];
            bct_pkg::RegYawSin: sin_ff <= csr_pwdata[17:0];
            bct_pkg::RegOriginX: ox_ff <= csr_pwdata;
            bct_pkg::RegOriginY: oy_ff <= csr_pwdata;
            bct_pkg::RegOriginZ: oz_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ridx)
         bct_pkg::RegBoneMask: csr_prdata = mask_ff;
         bct_pkg::RegYawCos: csr_prdata = {{14{cos_ff[17]}}, cos_ff};
         bct_pkg::RegYawSin: csr_prdata = {{14{sin_ff[17]}}, sin_ff};
         bct_pkg::RegOriginX: csr_prdata = ox_ff;
         bct_pkg::RegOriginY: csr_prdata = oy_ff;
         bct_pkg::RegOriginZ: csr_prdata = oz_ff;
         default: csr_prdata = '0;
      endcase
   end

   bct_pkg::state_type st_ff, st_in;
   logic [1:0] cnt_ff, cnt_in, row_ff;
   logic [7:0] bi_ff;
   logic signed [8:0] pi_ff;
   logic signed [17:0] qw_ff, qx_ff, qy_ff, qz_ff;
   logic signed [31:0] loc_ff [3];
   logic signed [31:0] lr_ff [9];
   logic use_root_ff, ok_ff;

   // Three products per cycle, registered and then combined into the local rotation entries.
   logic signed [36:0] pa, pb, pc;
   logic signed [17:0] ma0, mb0, ma1, mb1, ma2, mb2;
   always_comb begin
      case (cnt_ff)
         2'd0: begin ma0 = qx_ff; mb0 = qx_ff; ma1 = qy_ff; mb1 = qy_ff;
            ma2 = qz_ff; mb2 = qz_ff; end
         2'd1: begin ma0 = qx_ff; mb0 = qy_ff; ma1 = qx_ff; mb1 = qz_ff;
            ma2 = qy_ff; mb2 = qz_ff; end
         default: begin ma0 = qw_ff; mb0 = qx_ff; ma1 = qw_ff; mb1 = qy_ff;
            ma2 = qw_ff; mb2 = qz_ff; end
      endcase
      pa = 37'(ma0 * mb0); pb = 37'(ma1 * mb1); pc = 37'(ma2 * mb2);
   end

   logic signed [37:0] prod_ff [3][2];
   logic signed [37:0] sq_ff [3];

   function automatic logic signed [31:0] rnd(input logic signed [39:0] v);
      logic signed [39:0] t;
      t = v + 40'sd32768;
      return 32'(t >>> 16);
   endfunction

   localparam logic signed [39:0] One32 = 40'sd4294967296;

   logic signed [31:0] prow [4];
   logic [95:0] rd_data, wr_data;
   logic wr_en;
   logic [bct_pkg::MemAddrBits-1:0] addr;
   logic signed [69:0] acc [4];
   logic signed [31:0] wres [4];
   logic signed [31:0] out_ff [4];
   logic [7:0] ob_ff;
   logic [1:0] orow_ff;
   logic ovalid_ff;

   // The parent translation is kept in a second memory, one word per row.
   logic [95:0] rd_data_w;
   logic [31:0] rd_data_t;
   assign rd_data = rd_data_w;

   always_comb begin
      if (use_root_ff) begin
         case (row_ff)
            2'd0: begin prow[0] = 32'(cos_ff); prow[1] = -32'(sin_ff); prow[2] = '0;
               prow[3] = ox_ff; end
            2'd1: begin prow[0] = 32'(sin_ff); prow[1] = 32'(cos_ff); prow[2] = '0;
               prow[3] = oy_ff; end
            default: begin prow[0] = '0; prow[1] = '0; prow[2] = 32'sd65536;
               prow[3] = oz_ff; end
         endcase
      end else begin
         prow[0] = rd_data[31:0]; prow[1] = rd_data[63:32];
         prow[2] = rd_data[95:64]; prow[3] = '0;
      end
   end

   // World row: one row of P against all local columns.
   logic signed [31:0] ptr;
   always_comb begin
      ptr = use_root_ff ? prow[3] : $signed(rd_data_t);
      for (int j = 0; j < 3; j++)
         acc[j] = 70'(prow[0] * lr_ff[j]) + 70'(prow[1] * lr_ff[3+j])
                + 70'(prow[2] * lr_ff[6+j]);
      acc[3] = 70'(prow[0] * loc_ff[0]) + 70'(prow[1] * loc_ff[1])
             + 70'(prow[2] * loc_ff[2]) + 70'(ptr * 33'sd65536);
      for (int j = 0; j < 4; j++) wres[j] = bct_pkg::sat32((acc[j] + 70'sd32768) >>> 16);
   end

   logic [31:0] wr_t;
   bct_ram #(.Width(bct_pkg::MemWidth), .Depth(bct_pkg::MemDepth)) u_rot (
      .clock(clock), .wr_en(wr_en), .addr(addr), .wr_data(wr_data), .rd_data(rd_data_w));
   bct_ram #(.Width(32), .Depth(bct_pkg::MemDepth)) u_trn (
      .clock(clock), .wr_en(wr_en), .addr(addr), .wr_data(wr_t), .rd_data(rd_data_t));

   assign wr_data = {wres[2], wres[1], wres[0]};
   assign wr_t = wres[3];
   assign wr_en = (st_ff == bct_pkg::ST_ROW) && ok_ff && !ovalid_ff;
   always_comb begin
      if (st_ff == bct_pkg::ST_ROW)
         addr = {bi_ff, row_ff};
      else
         addr = {pi_ff[7:0], row_ff};
   end

   assign req_ready = (st_ff == bct_pkg::ST_IDLE);
   assign rsp_valid = ovalid_ff;
   assign rsp_out_bone = ob_ff;
   assign rsp_row = orow_ff;
   assign rsp_col0 = out_ff[0];
   assign rsp_col1 = out_ff[1];
   assign rsp_col2 = out_ff[2];
   assign rsp_translation = out_ff[3];
   assign rsp_last_row = (orow_ff == 2'd2);

   always_comb begin
      st_in = st_ff;
      cnt_in = cnt_ff;
      case (st_ff)
         bct_pkg::ST_IDLE:
            if (req_valid && (req_bone_flags & mask_ff) != '0) begin
               st_in = bct_pkg::ST_LOCAL; cnt_in = '0;
            end
         bct_pkg::ST_LOCAL: begin
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) st_in = bct_pkg::ST_READ;
         end
         bct_pkg::ST_READ: st_in = bct_pkg::ST_ROW;
         bct_pkg::ST_ROW: if (!ovalid_ff) st_in = bct_pkg::ST_OUT;
         bct_pkg::ST_OUT:
            if (!ovalid_ff || rsp_ready)
               st_in = (row_ff == 2'd2) ? bct_pkg::ST_IDLE : bct_pkg::ST_READ;
         default: st_in = bct_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= bct_pkg::ST_IDLE; cnt_ff <= '0; ovalid_ff <= 1'b0; row_ff <= '0;
      end else begin
         st_ff <= st_in; cnt_ff <= cnt_in;
         if (rsp_valid && rsp_ready) ovalid_ff <= 1'b0;
         if (st_ff == bct_pkg::ST_IDLE) row_ff <= '0;
         if (st_ff == bct_pkg::ST_ROW && !ovalid_ff) ovalid_ff <= 1'b1;
         if (st_ff == bct_pkg::ST_OUT && st_in != bct_pkg::ST_OUT && row_ff != 2'd2)
            row_ff <= row_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (st_ff == bct_pkg::ST_IDLE && req_valid) begin
         bi_ff <= req_bone_index; pi_ff <= req_parent_index;
         qw_ff <= req_quat_w; qx_ff <= req_quat_x; qy_ff <= req_quat_y; qz_ff <= req_quat_z;
         loc_ff[0] <= req_local_x; loc_ff[1] <= req_local_y; loc_ff[2] <= req_local_z;
         use_root_ff <= req_parent_index[8];
         ok_ff <= 1'b1;
      end
      if (st_ff == bct_pkg::ST_LOCAL) begin
         case (cnt_ff)
            2'd0: begin sq_ff[0] <= 38'(pa); sq_ff[1] <= 38'(pb); sq_ff[2] <= 38'(pc); end
            2'd1: begin prod_ff[0][0] <= 38'(pa); prod_ff[1][0] <= 38'(pb);
               prod_ff[2][0] <= 38'(pc); end
            2'd2: begin prod_ff[0][1] <= 38'(pc); prod_ff[1][1] <= 38'(pb);
               prod_ff[2][1] <= 38'(pa); end
            default: begin
               lr_ff[0] <= rnd(One32 - 40'(sq_ff[1] <<< 1) - 40'(sq_ff[2] <<< 1));
               lr_ff[4] <= rnd(One32 - 40'(sq_ff[0] <<< 1) - 40'(sq_ff[2] <<< 1));
               lr_ff[8] <= rnd(One32 - 40'(sq_ff[0] <<< 1) - 40'(sq_ff[1] <<< 1));
               lr_ff[3] <= rnd(40'(prod_ff[0][0] <<< 1) + 40'(prod_ff[0][1] <<< 1));
               lr_ff[1] <= rnd(40'(prod_ff[0][0] <<< 1) - 40'(prod_ff[0][1] <<< 1));
               lr_ff[6] <= rnd(40'(prod_ff[1][0] <<< 1) - 40'(prod_ff[1][1] <<< 1));
               lr_ff[2] <= rnd(40'(prod_ff[1][0] <<< 1) + 40'(prod_ff[1][1] <<< 1));
               lr_ff[7] <= rnd(40'(prod_ff[2][0] <<< 1) + 40'(prod_ff[2][1] <<< 1));
               lr_ff[5] <= rnd(40'(prod_ff[2][0] <<< 1) - 40'(prod_ff[2][1] <<< 1));
            end
         endcase
      end
      if (st_ff == bct_pkg::ST_ROW && !ovalid_ff) begin
         for (int j = 0; j < 4; j++) out_ff[j] <= wres[j];
         ob_ff <= bi_ff; orow_ff <= row_ff;
      end
   end
endmodule

// File: bench/bone_chain_transform_tb.sv
// Self-checking bench for bone_chain_transform: directed bones, then random bone chains.
// Expected matrix rows come from a bit-exact fixed-point predictor kept in this file.
// Depends on bct_pkg and the bone_chain_transform RTL.
`timescale 1ns / 1ps

module bone_chain_transform_tb;

   typedef struct {
      logic [7:0]         bone;
      logic signed [8:0]  parent;
      logic [31:0]        flags;
      logic signed [17:0] qw, qx, qy, qz;
      logic signed [31:0] lx, ly, lz;
      bit                 typed;
      logic [31:0]        tv[12];
   } bone_type;

   typedef struct {
      logic [7:0]  bone;
      logic [1:0]  row;
      logic [31:0] c0, c1, c2, tr;
      logic        last;
   } row_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_ready;
   logic [7:0] req_bone_index = 0;
   logic signed [8:0] req_parent_index = 0;
   logic [31:0] req_bone_flags = 0;
   logic signed [17:0] req_quat_w = 0, req_quat_x = 0, req_quat_y = 0, req_quat_z = 0;
   logic signed [31:0] req_local_x = 0, req_local_y = 0, req_local_z = 0;
   logic rsp_valid, rsp_ready = 0;
   logic [7:0] rsp_out_bone;
   logic [1:0] rsp_row;
   logic signed [31:0] rsp_col0, rsp_col1, rsp_col2, rsp_translation;
   logic rsp_last_row;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [4:0] csr_paddr = 0;
   logic [31:0] csr_pwdata = 0, csr_prdata;
   logic csr_pready;

   bone_chain_transform DUT (.*);

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   logic [31:0] mask_q = 0;
   longint yaw_cos_q = 65536, yaw_sin_q = 0, org_x_q = 0, org_y_q = 0, org_z_q = 0;
   logic signed [31:0] world_q[256][12];
   bit written_q[256];
   int written_list[$];
   row_type rows_due[$];
   int errors = 0;
   bit idle_on = 1;
   int stall = 0;

   function automatic longint rot_entry_q(longint base, longint t1, longint t2);
      logic signed [71:0] s;
      s = base;
      s = s + t1 + t2;
      s = (s + 72'sd32768) >>> 16;
      return longint'(s[63:0]);
   endfunction

   function automatic logic signed [31:0] clip32(logic signed [71:0] v);
      if (v > 72'sd2147483647) return 32'sh7fffffff;
      if (v < -72'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   task automatic predict_bone(input bone_type b);
      longint w, x, y, z, one32;
      longint L[3][4], P[3][4];
      logic signed [31:0] W[3][4];
      logic signed [71:0] acc;
      row_type r;
      if ((b.flags & mask_q) == 0) return;
      w = b.qw; x = b.qx; y = b.qy; z = b.qz;
      one32 = 64'sd1 <<< 32;
      L[0][0] = rot_entry_q(one32, -2 * y * y, -2 * z * z);
      L[1][0] = rot_entry_q(0, 2 * x * y, 2 * w * z);
      L[2][0] = rot_entry_q(0, 2 * x * z, -2 * w * y);
      L[0][1] = rot_entry_q(0, 2 * x * y, -2 * w * z);
      L[1][1] = rot_entry_q(one32, -2 * x * x, -2 * z * z);
      L[2][1] = rot_entry_q(0, 2 * y * z, 2 * w * x);
      L[0][2] = rot_entry_q(0, 2 * x * z, 2 * w * y);
      L[1][2] = rot_entry_q(0, 2 * y * z, -2 * w * x);
      L[2][2] = rot_entry_q(one32, -2 * x * x, -2 * y * y);
      L[0][3] = b.lx; L[1][3] = b.ly; L[2][3] = b.lz;
      if (b.parent < 0) begin
         P[0][0] = yaw_cos_q; P[0][1] = -yaw_sin_q; P[0][2] = 0; P[0][3] = org_x_q;
         P[1][0] = yaw_sin_q; P[1][1] = yaw_cos_q; P[1][2] = 0; P[1][3] = org_y_q;
         P[2][0] = 0; P[2][1] = 0; P[2][2] = 65536; P[2][3] = org_z_q;
      end else begin
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 4; j++)
               P[i][j] = world_q[b.parent[7:0]][i * 4 + j];
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 4; j++) begin
            acc = 0;
            for (int k = 0; k < 3; k++)
               acc = acc + P[i][k] * L[k][j];
            if (j == 3) acc = acc + P[i][3] * 65536;
            W[i][j] = clip32((acc + 72'sd32768) >>> 16);
            if (b.typed) W[i][j] = b.tv[i * 4 + j];
         end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 4; j++) world_q[b.bone][i * 4 + j] = W[i][j];
         r.bone = b.bone; r.row = i[1:0];
         r.c0 = W[i][0]; r.c1 = W[i][1]; r.c2 = W[i][2]; r.tr = W[i][3];
         r.last = (i == 2);
         rows_due.push_back(r);
      end
      if (!written_q[b.bone]) begin
         written_q[b.bone] = 1;
         written_list.push_back(b.bone);
      end
   endtask

   task automatic send_bone(input bone_type b);
      if (idle_on && $urandom_range(0, 99) < 27) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1;
      req_bone_index <= b.bone; req_parent_index <= b.parent; req_bone_flags <= b.flags;
      req_quat_w <= b.qw; req_quat_x <= b.qx; req_quat_y <= b.qy; req_quat_z <= b.qz;
      req_local_x <= b.lx; req_local_y <= b.ly; req_local_z <= b.lz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_bone(b);
   endtask

   task automatic drain;
      req_valid <= 0;
      while (rows_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] data);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= {idx, 2'b00}; csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      case (idx)
         bct_pkg::RegBoneMask: mask_q = data;
         bct_pkg::RegYawCos: yaw_cos_q = $signed(data[17:0]);
         bct_pkg::RegYawSin: yaw_sin_q = $signed(data[17:0]);
         bct_pkg::RegOriginX: org_x_q = $signed(data);
         bct_pkg::RegOriginY: org_y_q = $signed(data);
         bct_pkg::RegOriginZ: org_z_q = $signed(data);
         default: ;
      endcase
   endtask

   task automatic set_root(input logic [31:0] m, input int c, input int s,
                           input int ox, input int oy, input int oz);
      csr_write(bct_pkg::RegBoneMask, m);
      csr_write(bct_pkg::RegYawCos, c);
      csr_write(bct_pkg::RegYawSin, s);
      csr_write(bct_pkg::RegOriginX, ox);
      csr_write(bct_pkg::RegOriginY, oy);
      csr_write(bct_pkg::RegOriginZ, oz);
   endtask

   function automatic bone_type mk(int bone, int parent, logic [31:0] flags, int qw, int qx,
                                   int qy, int qz, int lx, int ly, int lz);
      bone_type b;
      b.bone = bone; b.parent = parent; b.flags = flags;
      b.qw = qw; b.qx = qx; b.qy = qy; b.qz = qz;
      b.lx = lx; b.ly = ly; b.lz = lz;
      b.typed = 0;
      foreach (b.tv[i]) b.tv[i] = 0;
      return b;
   endfunction

   function automatic bone_type rand_bone();
      bone_type b;
      int p;
      b = mk($urandom_range(0, 255), -1, $urandom, $urandom_range(0, 131072) - 65536,
             $urandom_range(0, 131072) - 65536, $urandom_range(0, 131072) - 65536,
             $urandom_range(0, 131072) - 65536, $urandom, $urandom, $urandom);
      if ($urandom_range(0, 99) < 85) b.flags |= mask_q & (~mask_q + 1);
      else if ($urandom_range(0, 1)) b.flags &= ~mask_q;
      p = $urandom_range(0, 99);
      if (p < 70 && written_list.size() != 0)
         b.parent = written_list[$urandom_range(0, written_list.size() - 1)];
      else if (p < 80)
         b.parent = -$signed($urandom_range(2, 256));
      if ($urandom_range(0, 3) == 0) b.lx = $urandom_range(0, 65535) - 32768;
      return b;
   endfunction

   task automatic check_row;
      row_type e;
      if (rows_due.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected item: bone %0d row %0d", rsp_out_bone, rsp_row);
         return;
      end
      e = rows_due.pop_front();
      if (e.bone !== rsp_out_bone || e.row !== rsp_row || e.c0 !== rsp_col0 ||
          e.c1 !== rsp_col1 || e.c2 !== rsp_col2 || e.tr !== rsp_translation ||
          e.last !== rsp_last_row) begin
         errors++;
         if (errors <= 10)
            $display({"mismatch: exp bone %0d row %0d %h %h %h %h last %0d, ",
                      "got bone %0d row %0d %h %h %h %h last %0d"},
                     e.bone, e.row, e.c0, e.c1, e.c2, e.tr, e.last, rsp_out_bone, rsp_row,
                     rsp_col0, rsp_col1, rsp_col2, rsp_translation, rsp_last_row);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) check_row();
      rsp_ready <= idle_on ? ($urandom_range(0, 99) >= 27) : 1'b1;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel)
         stall <= 0;
      else
         stall <= stall + 1;
      if (stall >= 4000) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      bone_type dir_tab[$];
      bone_type b;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Mask is zero after reset, so these bones are skipped.
      send_bone(mk(0, -1, 32'hffffffff, 65536, 0, 0, 0, 1, 2, 3));
      send_bone(mk(1, -1, 32'h0, 65536, 0, 0, 0, 1, 2, 3));
      drain();
      set_root(32'hffffffff, 65536, 0, 0, 0, 0);

      b = mk(0, -1, 32'h1, 65536, 0, 0, 0, 32'h7fffffff, 32'h80000000, 0);
      b.typed = 1;
      b.tv = '{65536, 0, 0, 32'h7fffffff, 0, 65536, 0, 32'h80000000, 0, 0, 65536, 0};
      dir_tab.push_back(b);
      b = mk(1, 0, 32'h80000000, 65536, 0, 0, 0, 1, 2, 3);
      b.typed = 1;
      b.tv = '{65536, 0, 0, 32'h7fffffff, 0, 65536, 0, 32'h80000002, 0, 0, 65536, 3};
      dir_tab.push_back(b);
      dir_tab.push_back(mk(2, 1, 32'h0, 65536, 0, 0, 0, 5, 5, 5));
      dir_tab.push_back(mk(2, 1, 32'h2, -65536, 0, 0, 0, 7, -7, 9));
      dir_tab.push_back(mk(3, -1, 32'h4, 0, 65536, 0, 0, 65536, 0, 0));
      dir_tab.push_back(mk(4, 3, 32'h8, 0, 0, 65536, 0, 0, 65536, 0));
      dir_tab.push_back(mk(5, 4, 32'h10, 0, 0, 0, 65536, 0, 0, 65536));
      dir_tab.push_back(mk(6, -1, 32'h20, 65536, 65536, 65536, 65536, 100, 200, 300));
      dir_tab.push_back(mk(7, 6, 32'h40, -65536, -65536, -65536, -65536, -1, -1, -1));
      dir_tab.push_back(mk(8, -1, 32'h100, 0, 0, 0, 0, 32'h80000000, 32'h7fffffff, 0));
      dir_tab.push_back(mk(9, 2, 32'hffff0000, 46341, 46341, 0, 0, 12345, -54321, 999));
      dir_tab.push_back(mk(255, -256, 32'h1, 46341, 0, -46341, 0, 65536, 65536, 65536));
      dir_tab.push_back(mk(10, 255, 32'h1, 32768, 32768, 32768, 32768, -65536, 0, 4));
      dir_tab.push_back(mk(11, -2, 32'h1, 65536, 0, 0, 0, 32'h7fffffff, 32'h7fffffff, 1));
      dir_tab.push_back(mk(255, 255, 32'h1, 0, 46341, 46341, 0, 3, 2, 1));
      dir_tab.push_back(mk(12, 7, 32'h1, -46341, 0, 0, 46341, 32'h80000000, -5, 32'h80000000));
      foreach (dir_tab[i]) send_bone(dir_tab[i]);
      drain();

      csr_write(3'd6, 32'hffffffff);
      csr_write(3'd7, 32'h12345678);
      set_root(32'hffffffff, -65536, 0, $urandom, $urandom, $urandom);
      repeat (40) send_bone(rand_bone());
      drain();

      idle_on = 0;
      set_root($urandom | (32'h1 << $urandom_range(0, 31)), 0, 65536,
               32'h7fffffff, 32'h80000000, 32'h7fffffff);
      repeat (40) send_bone(rand_bone());
      drain();

      idle_on = 1;
      set_root(32'h1, 46341, -65536, 32'h80000000, 32'h7fffffff, 32'h80000000);
      repeat (10) send_bone(rand_bone());
      drain();
      set_root(32'h80000000, 65536, 65536, -65536, 65536, 0);
      repeat (10) send_bone(rand_bone());
      drain();

      repeat (30) @(posedge clock);
      if (rows_due.size() != 0) errors++;
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

// File: sim.f
sv/bct_pkg.sv
sv/bct_ram.sv
sv/bone_chain_transform.sv
bench/bone_chain_transform_tb.sv
